/* src/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SUTB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sutb assertion failed");
`define SUTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sutb assertion failed");
`else
`define SUTB_ASSERT(lbl, clk, rstn, prop)
`define SUTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/sutb_pkg.sv */
// types shared by the sorted unique table builder modules
`timescale 1ns / 1ps
package sutb_pkg;

  localparam int unsigned InDataBits  = 32;
  localparam int unsigned OutValBits  = 32;
  localparam int unsigned OutCntBits  = 6;
  localparam int unsigned OutDataBits = 40;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_OUT
  } sutb_state_e;

  typedef enum logic {
    MODE_COUNT,
    MODE_EMIT
  } sutb_mode_e;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic store;
    logic scan_start;
    logic scan_rd;
    logic take_best;
    logic count_inc;
    logic restart;
    logic emit;
    logic next_out;
    logic finish;
  } sutb_cmd_t;

  typedef struct packed {
    logic last_issued;
    logic best_vld;
    logic out_last;
  } sutb_stat_t;

endpackage

/* src/sutb_ctrl.sv */
// controller state machine for the sorted unique table builder
`timescale 1ns / 1ps
module sutb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  input  logic               out_ready_i,
  input  sutb_pkg::sutb_stat_t stat_i,
  output sutb_pkg::sutb_cmd_t  cmd_o
);

  sutb_pkg::sutb_state_e state_q, state_d;
  sutb_pkg::sutb_mode_e  mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sutb_pkg::S_LOAD;
      mode_q  <= sutb_pkg::MODE_COUNT;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    case (state_q)
      sutb_pkg::S_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = sutb_pkg::S_SCAN;
        end
      end
      sutb_pkg::S_SCAN: begin
        if (stat_i.last_issued) begin
          state_d = sutb_pkg::S_DRAIN;
        end
      end
      sutb_pkg::S_DRAIN: begin
        state_d = sutb_pkg::S_DECIDE;
      end
      sutb_pkg::S_DECIDE: begin
        if (mode_q == sutb_pkg::MODE_COUNT) begin
          state_d = sutb_pkg::S_SCAN;
          if (!stat_i.best_vld) begin
            mode_d = sutb_pkg::MODE_EMIT;
          end
        end else begin
          state_d = sutb_pkg::S_OUT;
        end
      end
      sutb_pkg::S_OUT: begin
        if (out_ready_i) begin
          if (stat_i.out_last) begin
            state_d = sutb_pkg::S_LOAD;
            mode_d  = sutb_pkg::MODE_COUNT;
          end else begin
            state_d = sutb_pkg::S_SCAN;
          end
        end
      end
      default: begin
        state_d = sutb_pkg::S_LOAD;
        mode_d  = sutb_pkg::MODE_COUNT;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      sutb_pkg::S_LOAD: begin
        cmd_o.in_ready   = 1'b1;
        cmd_o.store      = in_valid_i;
        cmd_o.scan_start = in_valid_i && in_last_i;
      end
      sutb_pkg::S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      sutb_pkg::S_DRAIN: begin
        cmd_o = '0;
      end
      sutb_pkg::S_DECIDE: begin
        if (mode_q == sutb_pkg::MODE_COUNT) begin
          cmd_o.scan_start = 1'b1;
          if (stat_i.best_vld) begin
            cmd_o.take_best = 1'b1;
            cmd_o.count_inc = 1'b1;
          end else begin
            cmd_o.restart = 1'b1;
          end
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
      sutb_pkg::S_OUT: begin
        cmd_o.out_valid = 1'b1;
        if (out_ready_i) begin
          if (stat_i.out_last) begin
            cmd_o.finish = 1'b1;
          end else begin
            cmd_o.take_best  = 1'b1;
            cmd_o.next_out   = 1'b1;
            cmd_o.scan_start = 1'b1;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* src/sutb_datapath.sv */
// value store, minimum search and result registers
`timescale 1ns / 1ps
module sutb_datapath #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sutb_pkg::sutb_cmd_t                 cmd_i,
  input  logic [sutb_pkg::InDataBits-1:0]     freq_khz_i,
  output sutb_pkg::sutb_stat_t                stat_o,
  output logic [sutb_pkg::OutValBits-1:0]     sorted_khz_o,
  output logic [sutb_pkg::OutCntBits-1:0]     distinct_count_o,
  output logic                                overflow_o,
  output logic                                last_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0] mem_q [DEPTH];

  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  logic                  rd_vld_q;
  logic [VALUE_BITS-1:0] rd_data_q;
  logic [VALUE_BITS-1:0] prev_q;
  logic                  have_prev_q, have_prev_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic                  best_vld_q, best_vld_d;
  logic [CW-1:0]         distinct_q, distinct_d;
  logic [CW-1:0]         emit_idx_q, emit_idx_d;
  logic [VALUE_BITS-1:0] out_val_q;
  logic                  out_last_q;

  logic [VALUE_BITS+sutb_pkg::InDataBits-1:0] in_wide;
  logic [VALUE_BITS+sutb_pkg::OutValBits-1:0] out_wide;
  logic [CW+sutb_pkg::OutCntBits-1:0]         cnt_wide;
  logic                                       store_ok;
  logic                                       cand;

  assign in_wide  = {{VALUE_BITS{1'b0}}, freq_khz_i};
  assign store_ok = cnt_q < CW'(DEPTH);

  // candidate: above the last picked value and below the best so far
  assign cand = rd_vld_q && (!have_prev_q || (rd_data_q > prev_q)) &&
                (!best_vld_q || (rd_data_q < best_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && store_ok) begin
      mem_q[cnt_q[AW-1:0]] <= in_wide[VALUE_BITS-1:0];
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    rd_idx_d    = rd_idx_q;
    have_prev_d = have_prev_q;
    best_d      = best_q;
    best_vld_d  = best_vld_q;
    distinct_d  = distinct_q;
    emit_idx_d  = emit_idx_q;
    if (cmd_i.store) begin
      if (store_ok) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cand) begin
      best_d     = rd_data_q;
      best_vld_d = 1'b1;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_d = rd_idx_q + AW'(1);
    end
    if (cmd_i.scan_start) begin
      rd_idx_d   = '0;
      best_vld_d = 1'b0;
    end
    if (cmd_i.take_best) begin
      have_prev_d = 1'b1;
    end
    if (cmd_i.count_inc) begin
      distinct_d = distinct_q + CW'(1);
    end
    if (cmd_i.next_out) begin
      emit_idx_d = emit_idx_q + CW'(1);
    end
    if (cmd_i.restart) begin
      have_prev_d = 1'b0;
      emit_idx_d  = '0;
    end
    if (cmd_i.finish) begin
      cnt_d       = '0;
      ovf_d       = 1'b0;
      have_prev_d = 1'b0;
      distinct_d  = '0;
      emit_idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
      best_vld_q  <= 1'b0;
      distinct_q  <= '0;
      emit_idx_q  <= '0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= cmd_i.scan_rd;
      have_prev_q <= have_prev_d;
      best_vld_q  <= best_vld_d;
      distinct_q  <= distinct_d;
      emit_idx_q  <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (cmd_i.take_best) begin
      prev_q <= best_q;
    end
    if (cmd_i.emit) begin
      out_val_q  <= best_q;
      out_last_q <= (emit_idx_q + CW'(1)) == distinct_q;
    end
  end

  assign stat_o.last_issued = (CW'(rd_idx_q) + CW'(1)) == cnt_q;
  assign stat_o.best_vld    = best_vld_q;
  assign stat_o.out_last    = out_last_q;

  assign out_wide         = {{sutb_pkg::OutValBits{1'b0}}, out_val_q};
  assign cnt_wide         = {{sutb_pkg::OutCntBits{1'b0}}, distinct_q};
  assign sorted_khz_o     = out_wide[sutb_pkg::OutValBits-1:0];
  assign distinct_count_o = cnt_wide[sutb_pkg::OutCntBits-1:0];
  assign overflow_o       = ovf_q;
  assign last_out_o       = out_last_q;

endmodule

/* src/sorted_unique_table_builder_unit.sv */
// top level of the sorted unique table builder
//
//   port group   dir  tdata (low bit up)                          tlast
//   s_axis       in   freq_khz[31:0]                              last_entry
//   m_axis       out  sorted_khz[31:0] distinct_count[37:32]      last_out
//                     overflow[38] zero[39]
//
// each input transfer takes one cycle; s_axis_tready_o is low from a last
// transfer until the final result of that run has been taken
// with d distinct values held, a run makes 2d+1 passes over the store after its
// last transfer: every pass reads the one store port once per entry
// reset clears counters and flags at once; no clearing pass over the store
// results wait in the output register while m_axis_tready_i is low
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_unique_table_builder_unit #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [sutb_pkg::InDataBits-1:0]     s_axis_tdata_i,  // freq_khz
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // sorted_khz, distinct_count, overflow, zero pad
  output logic [sutb_pkg::OutDataBits-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  sutb_pkg::sutb_cmd_t  cmd;
  sutb_pkg::sutb_stat_t stat;

  logic [sutb_pkg::OutValBits-1:0] sorted_khz;
  logic [sutb_pkg::OutCntBits-1:0] distinct_count;
  logic                            overflow;
  logic                            last_out;

  sutb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sutb_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .freq_khz_i       (s_axis_tdata_i),
    .stat_o           (stat),
    .sorted_khz_o     (sorted_khz),
    .distinct_count_o (distinct_count),
    .overflow_o       (overflow),
    .last_out_o       (last_out)
  );

  assign s_axis_tready_o = cmd.in_ready;
  assign m_axis_tvalid_o = cmd.out_valid;
  assign m_axis_tdata_o  = {1'b0, overflow, distinct_count, sorted_khz};
  assign m_axis_tlast_o  = last_out;

  `SUTB_ASSERT(a_no_load_during_emit, clk_i, rst_ni, !(s_axis_tready_o && m_axis_tvalid_o))
  `SUTB_ASSERT_NEXT(a_last_in_stops_load, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o)
  `SUTB_ASSERT_NEXT(a_last_out_reopens, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o && !m_axis_tvalid_o)

endmodule

/* test/sorted_unique_table_builder_unit_tb.sv */
// testbench for the sorted unique table builder, checked against a predicted table
`timescale 1ns / 1ps
module sorted_unique_table_builder_unit_tb;

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned ValBits    = 32;
  localparam int unsigned CntBits    = sutb_pkg::OutCntBits;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned MaxShown   = 10;

  typedef enum int unsigned {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  typedef struct {
    logic [sutb_pkg::InDataBits-1:0] freq;
    logic                            last;
    pace_e                           pace;
    logic                            hold;
  } freq_item_t;

  typedef struct packed {
    logic [sutb_pkg::OutValBits-1:0] khz;
    logic [CntBits-1:0]              cnt;
    logic                            ovf;
    logic                            last;
  } table_row_t;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [sutb_pkg::InDataBits-1:0]  s_axis_tdata_i  = '0;
  logic                             s_axis_tlast_i  = 1'b0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [sutb_pkg::OutDataBits-1:0] m_axis_tdata_o;
  logic                             m_axis_tlast_o;

  freq_item_t       feed_q[$];
  table_row_t       table_q[$];
  logic [ValBits-1:0] held_vals[StoreDepth];
  int unsigned      held_cnt   = 0;
  logic             dropped    = 1'b0;
  int unsigned      mismatches = 0;
  logic             in_fire    = 1'b0;
  pace_e            rx_pace    = PACE_FREE;
  logic             hold_req   = 1'b0;
  logic             hold_taken = 1'b0;
  int unsigned      hold_left  = 0;

  sorted_unique_table_builder_unit #(
    .DEPTH     (StoreDepth),
    .VALUE_BITS(ValBits)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic add_item(input logic [sutb_pkg::InDataBits-1:0] f, input logic l,
                          input pace_e p, input logic h);
    freq_item_t it;
    it.freq = f;
    it.last = l;
    it.pace = p;
    it.hold = h;
    feed_q.push_back(it);
  endtask

  function automatic logic [sutb_pkg::InDataBits-1:0] pick_freq(input logic crowded);
    if (crowded) begin
      return 32'd100000 * $urandom_range(0, 5);
    end
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return 32'd100000 * $urandom_range(1, 20);
      default: return $urandom();
    endcase
  endfunction

  // store the value, and on the final one build the ascending distinct table
  task automatic absorb_freq(input logic [sutb_pkg::InDataBits-1:0] freq, input logic last);
    logic [ValBits-1:0] uniq[$];
    int unsigned pos;
    table_row_t row;
    if (held_cnt < StoreDepth) begin
      held_vals[held_cnt] = freq[ValBits-1:0];
      held_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      for (int unsigned i = 0; i < held_cnt; i++) begin
        pos = 0;
        while (pos < uniq.size() && uniq[pos] < held_vals[i]) pos++;
        if (pos == uniq.size() || uniq[pos] != held_vals[i]) uniq.insert(pos, held_vals[i]);
      end
      foreach (uniq[k]) begin
        row.khz  = uniq[k];
        row.cnt  = CntBits'(uniq.size());
        row.ovf  = dropped;
        row.last = (k == uniq.size() - 1);
        table_q.push_back(row);
      end
      held_cnt = 0;
      dropped  = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxShown) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    in_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      absorb_freq(s_axis_tdata_i, s_axis_tlast_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    table_row_t want;
    logic [sutb_pkg::OutDataBits-1:0] want_data;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (table_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result khz=%0d cnt=%0d ovf=%0b last=%0b",
                                m_axis_tdata_o[31:0], m_axis_tdata_o[37:32],
                                m_axis_tdata_o[38], m_axis_tlast_o));
      end else begin
        want      = table_q.pop_front();
        want_data = {1'b0, want.ovf, want.cnt, want.khz};
        if (m_axis_tdata_o !== want_data || m_axis_tlast_o !== want.last) begin
          note_mismatch($sformatf(
            "exp khz=%0d cnt=%0d ovf=%0b last=%0b got khz=%0d cnt=%0d ovf=%0b pad=%0b last=%0b",
            want.khz, want.cnt, want.ovf, want.last, m_axis_tdata_o[31:0],
            m_axis_tdata_o[37:32], m_axis_tdata_o[38], m_axis_tdata_o[39], m_axis_tlast_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin : feeder
    freq_item_t it;
    int unsigned idle_pct;
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      if (feed_q.size() > 0) begin
        idle_pct = (feed_q[0].pace == PACE_SEND_IDLE) ? 61 :
                   (feed_q[0].pace == PACE_BOTH) ? 17 : 0;
        if ($urandom_range(0, 99) < idle_pct) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          it = feed_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= it.freq;
          s_axis_tlast_i  <= it.last;
          rx_pace         <= it.pace;
          if (it.hold) hold_req <= 1'b1;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // long hold-off so results back up and the input stalls
  always @(negedge clk_i) begin : drain_pacer
    int unsigned stall_pct;
    if (hold_req && !hold_taken) begin
      hold_left  = HoldCycles;
      hold_taken = 1'b1;
    end
    stall_pct = (rx_pace == PACE_RECV_STALL) ? 61 : (rx_pace == PACE_BOTH) ? 17 : 0;
    if (rst_ni) begin
      m_axis_tready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
    if (hold_left > 0) hold_left--;
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned total;
    pace_e pace;
    // single value runs at both ends of the range
    add_item(32'h0000_0000, 1'b1, PACE_FREE, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b1, PACE_FREE, 1'b0);
    // all values equal
    add_item(32'd5, 1'b0, PACE_FREE, 1'b0);
    add_item(32'd5, 1'b0, PACE_FREE, 1'b0);
    add_item(32'd5, 1'b1, PACE_FREE, 1'b0);
    // unordered with duplicates and extremes
    add_item(32'hFFFF_FFFF, 1'b0, PACE_FREE, 1'b0);
    add_item(32'h0000_0000, 1'b0, PACE_FREE, 1'b0);
    add_item(32'd7, 1'b0, PACE_FREE, 1'b0);
    add_item(32'h0000_0000, 1'b0, PACE_FREE, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0, PACE_FREE, 1'b0);
    add_item(32'd7, 1'b1, PACE_FREE, 1'b0);
    // bit patterns
    add_item(32'h8000_0000, 1'b0, PACE_FREE, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b0, PACE_FREE, 1'b0);
    add_item(32'h0000_0001, 1'b0, PACE_FREE, 1'b0);
    add_item(32'hAAAA_AAAA, 1'b0, PACE_FREE, 1'b0);
    add_item(32'h5555_5555, 1'b1, PACE_FREE, 1'b0);

    total = 0;
    for (int unsigned run = 0; total < 94; run++) begin
      pace = pace_e'((run / 3) % 4);
      if (run == 1) begin
        len = StoreDepth;
      end else if (run == 6) begin
        // store overruns, with values drawn from six multiples of 100000
        len = StoreDepth + 2;
      end else begin
        len = $urandom_range(1, 8);
      end
      for (int unsigned i = 0; i < len; i++) begin
        add_item(pick_freq(run == 6), i == len - 1, pace, run == 4 && i == 0);
      end
      total += len;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (table_q.size() > 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && table_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/sutb_pkg.sv
src/sutb_ctrl.sv
src/sutb_datapath.sv
src/sorted_unique_table_builder_unit.sv
test/sorted_unique_table_builder_unit_tb.sv
